>>> design/cseq_pkg.sv
// ----------------------------------------------------------------------------
// Cursor sequence store package
// Shared request and result types, command codes, controller states and the
// control word broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
package cseq_pkg;

    // Wide enough for a position or cursor at the largest supported depth.
    localparam int POS_W = 11;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_ATTACH  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_START   = 3'd3,
        OP_ADVANCE = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic [31:0] current_value;
        logic        has_current;
        logic [6:0]  item_count;
        logic        rejected;
    } result_t;

    typedef struct packed {
        logic             load;
        logic             shift_up;
        logic             shift_down;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cursor;
    } cell_ctrl_t;

endpackage

>>> design/cseq_cell.sv
// ----------------------------------------------------------------------------
// Cursor sequence store cell
// Holds one entry of the sequence. Loads a new value, takes its lower or
// upper neighbour's entry during a shift, or holds, and presents its entry
// on the read tap when the cursor points at it.
// ----------------------------------------------------------------------------
module cseq_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    clk,
    input  cseq_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_WIDTH-1:0]  load_value,
    input  logic [VALUE_WIDTH-1:0]  lower_data,
    input  logic [VALUE_WIDTH-1:0]  upper_data,
    output logic [VALUE_WIDTH-1:0]  data,
    output logic [VALUE_WIDTH-1:0]  tap
);
    import cseq_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load && (ctrl.pos == MY_POS))
        begin
            data_next = load_value;
        end
        else if (ctrl.shift_up && (MY_POS > ctrl.pos))
        begin
            data_next = lower_data;
        end
        else if (ctrl.shift_down && (MY_POS >= ctrl.pos))
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (ctrl.cursor == MY_POS) ? data_reg : '0;

endmodule

>>> design/cursor_sequence_store.sv
// ----------------------------------------------------------------------------
// Cursor sequence store
// Ordered list of up to DEPTH values with a cursor, held in a row of cells.
// ----------------------------------------------------------------------------
// When a request is taken, the row of cells shifts all entries at once to
// open or close a slot and the controller enters its report state, where
// the entry under the cursor is gathered from the row and shown on result
// with done high. busy is high in the report state, so no new request is
// taken before the last one is reported. Results cannot be held off; done
// lasts exactly one cycle. An insert or attach into a full store changes
// nothing and reports rejected. There is no clearing pass after reset.
module cursor_sequence_store #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cseq_pkg::request_t  request,
    output logic                busy,
    output logic                done,
    output cseq_pkg::result_t   result
);
    import cseq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      cursor_reg;
    logic [CW-1:0]      cursor_next;
    logic               rejected_reg;
    logic               rejected_next;

    logic               accept;
    logic               cur_valid;
    logic               full;
    logic [CW-1:0]      place_pos;
    cell_ctrl_t         ctrl;
    logic [VALUE_WIDTH-1:0] load_value;
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_tap  [DEPTH];
    logic [VALUE_WIDTH-1:0] read_value;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cur_valid = cursor_reg < count_reg;
    assign full      = count_reg == CW'(DEPTH);
    assign load_value = VALUE_WIDTH'(request.value);

    // Command decode: new count, cursor and the shift broadcast to the row.
    always_comb
    begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        rejected_next = rejected_reg;
        place_pos     = '0;
        ctrl          = '0;
        ctrl.cursor   = POS_W'(cursor_reg);
        if (accept)
        begin
            rejected_next = 1'b0;
            case (request.op)
                OP_INSERT, OP_ATTACH:
                begin
                    if (full)
                    begin
                        rejected_next = 1'b1;
                    end
                    else
                    begin
                        if (request.op == OP_INSERT)
                        begin
                            place_pos = cur_valid ? cursor_reg : '0;
                        end
                        else
                        begin
                            place_pos = cur_valid ? cursor_reg + 1'b1 : count_reg;
                        end
                        ctrl.load     = 1'b1;
                        ctrl.shift_up = 1'b1;
                        ctrl.pos      = POS_W'(place_pos);
                        count_next    = count_reg + 1'b1;
                        cursor_next   = place_pos;
                    end
                end
                OP_REMOVE:
                begin
                    // The cursor keeps its place; on the last item it lands
                    // on the new count, which means no current item.
                    if (cur_valid)
                    begin
                        ctrl.shift_down = 1'b1;
                        ctrl.pos        = POS_W'(cursor_reg);
                        count_next      = count_reg - 1'b1;
                    end
                end
                OP_START:
                begin
                    cursor_next = '0;
                end
                OP_ADVANCE:
                begin
                    if (cur_valid)
                    begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
                default:
                begin
                    cursor_next = cursor_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            rejected_reg <= rejected_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] lower;
            logic [VALUE_WIDTH-1:0] upper;
            if (gi == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_inner_lo
                assign lower = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign upper = cell_data[gi];
            end
            else
            begin : g_inner_hi
                assign upper = cell_data[gi+1];
            end
            cseq_cell #(
                .INDEX       (gi),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_value (load_value),
                .lower_data (lower),
                .upper_data (upper),
                .data       (cell_data[gi]),
                .tap        (cell_tap[gi])
            );
        end
    endgenerate

    // Only the cell under the cursor drives a non-zero tap.
    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_value = read_value | cell_tap[i];
        end
    end

    always_comb
    begin
        busy   = state_reg == ST_REPORT;
        done   = state_reg == ST_REPORT;
        result = '0;
        if (state_reg == ST_REPORT)
        begin
            result.current_value = cur_valid ? 32'(read_value) : '0;
            result.has_current   = cur_valid;
            result.item_count    = 7'(count_reg);
            result.rejected      = rejected_reg;
        end
    end

endmodule

>>> design/cseq_checker.sv
// ----------------------------------------------------------------------------
// Cursor sequence store checker
// Watches the ports of the store and checks the request to result timing
// and the consistency of each result.
// ----------------------------------------------------------------------------
module cseq_checker #(
    parameter int DEPTH = 64
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input cseq_pkg::request_t  request,
    input logic                busy,
    input logic                done,
    input cseq_pkg::result_t   result
);
    import cseq_pkg::*;

    // Every accepted request yields its result in the following cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request accepted without a result one cycle later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result given without a preceding request");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_current) |-> (result.current_value == 32'd0))
        else $error("non-zero value reported with no current item");

    a_current_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.has_current) |-> (result.item_count != 7'd0))
        else $error("current item reported on an empty store");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.rejected) |->
            ((result.item_count == 7'(DEPTH)) &&
             (($past(request.op) == OP_INSERT) || ($past(request.op) == OP_ATTACH))))
        else $error("rejection reported for a request that could not be rejected");

endmodule

bind cursor_sequence_store cseq_checker #(.DEPTH(DEPTH)) u_checker (.*);

>>> dv/cursor_sequence_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cursor sequence store testbench
// Drives insert, attach, remove, start, advance and read requests into the
// store and checks every result against a behavioural copy of the list and
// cursor. A short directed run covers the empty store, the ends of the list
// and the edge values. Random runs then fill the store until it rejects,
// drain it to empty and walk the cursor. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module cursor_sequence_store_tb;

    import cseq_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int          RANDOM_ITEMS = 1280;
    localparam int          LIMIT_CYCLES = 200000;
    // Undefined command codes; the store treats them as a plain read.
    localparam logic [2:0]  OP_SPARE_6   = 3'd6;
    localparam logic [2:0]  OP_SPARE_7   = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ROAM
    } mix_t;

    typedef struct {
        request_t req;
        bit       drain_first;
    } pending_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;

    pending_t pending_q[$];
    result_t  expected_q[$];

    // Behavioural copy of the store.
    logic [31:0] shadow_items[DEPTH];
    int          shadow_count;
    int          shadow_cursor;

    int cycle_count;
    int issued_count;
    int accepted_count;
    int result_count;
    int error_count;
    int reject_count;
    int peak_count;
    int empty_hits;

    cursor_sequence_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (32)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one command to the shadow list and returns the state it leaves.
    function automatic result_t apply_command(request_t req);
        result_t res;
        int      pos;
        int      i;
        bit      on_item;
        res     = '0;
        on_item = shadow_cursor < shadow_count;
        case (req.op)
            OP_INSERT, OP_ATTACH:
            begin
                if (shadow_count >= DEPTH)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    if (req.op == OP_INSERT)
                        pos = on_item ? shadow_cursor : 0;
                    else
                        pos = on_item ? shadow_cursor + 1 : shadow_count;
                    for (i = shadow_count; i > pos; i--)
                        shadow_items[i] = shadow_items[i - 1];
                    shadow_items[pos] = req.value;
                    shadow_count++;
                    shadow_cursor = pos;
                end
            end
            OP_REMOVE:
            begin
                if (on_item)
                begin
                    for (i = shadow_cursor; i + 1 < shadow_count; i++)
                        shadow_items[i] = shadow_items[i + 1];
                    shadow_count--;
                    if (shadow_cursor > shadow_count)
                        shadow_cursor = shadow_count;
                end
            end
            OP_START:
                shadow_cursor = 0;
            OP_ADVANCE:
            begin
                if (on_item)
                    shadow_cursor++;
            end
            default:
                ;
        endcase
        if (shadow_cursor < shadow_count)
        begin
            res.current_value = shadow_items[shadow_cursor];
            res.has_current   = 1'b1;
        end
        res.item_count = shadow_count[6:0];
        if (res.rejected)
            reject_count++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        if (shadow_count == 0 && !on_item && req.op == OP_REMOVE)
            empty_hits++;
        return res;
    endfunction

    function automatic logic [31:0] fresh_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_op(mix_t mix);
        int r;
        int w_ins;
        int w_att;
        int w_rem;
        int w_sta;
        int w_adv;
        int w_rd;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin w_ins = 40; w_att = 40; w_rem = 5;  w_sta = 5;  w_adv = 5;  end
            MIX_DRAIN: begin w_ins = 10; w_att = 10; w_rem = 45; w_sta = 10; w_adv = 15; end
            default:   begin w_ins = 15; w_att = 15; w_rem = 15; w_sta = 15; w_adv = 30; end
        endcase
        w_rd = 100 - w_ins - w_att - w_rem - w_sta - w_adv;
        if (r < w_ins)
            return OP_INSERT;
        r -= w_ins;
        if (r < w_att)
            return OP_ATTACH;
        r -= w_att;
        if (r < w_rem)
            return OP_REMOVE;
        r -= w_rem;
        if (r < w_sta)
            return OP_START;
        r -= w_sta;
        if (r < w_adv)
            return OP_ADVANCE;
        r -= w_adv;
        // Most of what is left is a plain read; the rest are unused codes.
        if (r < w_rd - 2)
            return OP_READ;
        return (r == w_rd - 2) ? OP_SPARE_6 : OP_SPARE_7;
    endfunction

    task automatic queue_request(logic [2:0] op, logic [31:0] value, bit drain_first);
        pending_t p;
        p.req.op      = op;
        p.req.value   = value;
        p.drain_first = drain_first;
        pending_q.push_back(p);
    endtask

    // Holds the next request back for a random gap, or until the store has
    // answered everything when the request asks for a quiet store first.
    function automatic bit pending_pause(int idle_pct);
        if (pending_q.size() == 0)
            return 1'b1;
        if (pending_q[0].drain_first && (expected_q.size() != 0 || start))
            return 1'b1;
        return $urandom_range(99) < idle_pct;
    endfunction

    // Driver: a request is taken at an edge where start is high and busy low.
    always @(posedge clk)
    begin : driver
        logic     slot_free;
        logic     next_start;
        int       idle_pct;
        pending_t p;
        if (rst_n)
        begin
            slot_free  = !start || !busy;
            next_start = start;
            if (start && !busy)
            begin
                expected_q.push_back(apply_command(request));
                accepted_count++;
            end
            if (slot_free)
            begin
                next_start = 1'b0;
                if (issued_count < pending_q.size() + issued_count)
                begin
                    if (issued_count < RANDOM_ITEMS / 3)
                        idle_pct = 38;
                    else if (issued_count < 2 * RANDOM_ITEMS / 3)
                        idle_pct = 83;
                    else
                        idle_pct = 0;
                    if (pending_pause(idle_pct))
                    begin
                        next_start = 1'b0;
                    end
                    else
                    begin
                        p = pending_q.pop_front();
                        request <= p.req;
                        next_start = 1'b1;
                        issued_count++;
                    end
                end
            end
            start <= next_start;
        end
    end

    // Monitor: every done cycle carries exactly one result.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no request outstanding: %h", $time, result);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.current_value !== want.current_value)
                begin
                    error_count++;
                    $display("%0t: current_value expected %h actual %h",
                             $time, want.current_value, result.current_value);
                end
                if (result.has_current !== want.has_current)
                begin
                    error_count++;
                    $display("%0t: has_current expected %b actual %b",
                             $time, want.has_current, result.has_current);
                end
                if (result.item_count !== want.item_count)
                begin
                    error_count++;
                    $display("%0t: item_count expected %0d actual %0d",
                             $time, want.item_count, result.item_count);
                end
                if (result.rejected !== want.rejected)
                begin
                    error_count++;
                    $display("%0t: rejected expected %b actual %b",
                             $time, want.rejected, result.rejected);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   n;
        int   len;
        int   i;
        mix_t mix;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cycle_count    = 0;
        issued_count   = 0;
        accepted_count = 0;
        result_count   = 0;
        error_count    = 0;
        reject_count   = 0;
        peak_count     = 0;
        empty_hits     = 0;
        shadow_count   = 0;
        shadow_cursor  = 0;

        // Empty store: every command that needs a current item does nothing.
        queue_request(OP_READ,    32'h0, 1'b0);
        queue_request(OP_REMOVE,  32'h0, 1'b0);
        queue_request(OP_ADVANCE, 32'h0, 1'b0);
        queue_request(OP_START,   32'h0, 1'b0);
        queue_request(OP_SPARE_6, 32'hFFFF_FFFF, 1'b0);
        // Build a short list from both sides of the cursor.
        queue_request(OP_INSERT,  32'hFFFF_FFFF, 1'b0);
        queue_request(OP_ATTACH,  32'h0000_0000, 1'b0);
        queue_request(OP_INSERT,  32'h1234_5678, 1'b0);
        queue_request(OP_ATTACH,  32'hA5A5_A5A5, 1'b0);
        // Walk off the end, then insert with no current item: goes in front.
        queue_request(OP_START,   32'h0, 1'b0);
        for (i = 0; i < 5; i++)
            queue_request(OP_ADVANCE, 32'h0, 1'b0);
        queue_request(OP_INSERT,  32'h8000_0001, 1'b0);
        // Again off the end; attach with no current item goes at the back.
        for (i = 0; i < 5; i++)
            queue_request(OP_ADVANCE, 32'h0, 1'b0);
        queue_request(OP_ATTACH,  32'h7FFF_FFFE, 1'b0);
        // Removing the last item leaves no current item.
        queue_request(OP_REMOVE,  32'h0, 1'b0);
        queue_request(OP_SPARE_7, 32'h0, 1'b0);
        queue_request(OP_START,   32'h0, 1'b0);
        queue_request(OP_REMOVE,  32'h5555_5555, 1'b0);

        // Random part opens with a fill well past capacity so that full-store
        // rejection is always reached; later stretches mix fill, drain and roam.
        n = 0;
        for (i = 0; i < 72; i++)
        begin
            queue_request(($urandom_range(1) != 0) ? OP_INSERT : OP_ATTACH,
                          fresh_value(), i == 0);
            n++;
        end
        while (n < RANDOM_ITEMS)
        begin
            mix = mix_t'($urandom_range(2));
            len = $urandom_range(30, 90);
            for (i = 0; i < len && n < RANDOM_ITEMS; i++)
            begin
                // Phase changes and the odd random point wait for a quiet store.
                queue_request(pick_op(mix), fresh_value(),
                              n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3 ||
                              $urandom_range(99) == 0);
                n++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Ran %0d requests, %0d results; %0d rejected at full, peak of %0d items.",
                 accepted_count, result_count, reject_count, peak_count);
        $display("Removes on an empty store: %0d; %0d mismatches.",
                 empty_hits, error_count);
        if (error_count == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
